FILE: src/oaie_pkg.sv
`default_nettype none
package oaie_pkg;

  // Storage geometry
  localparam int DEPTH     = 64;
  localparam int WORD_BITS = 32;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);

  // Fixed field widths of the channels
  localparam int OP_W   = 4;
  localparam int IDX_W  = 7;
  localparam int DATA_W = 32;
  localparam int SIZE_W = 7;
  localparam int ST_W   = 2;

  // Width for comparing counts against index and size fields
  localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  typedef logic [OP_W-1:0]          op_t;
  typedef logic [ST_W-1:0]          status_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic signed [WORD_BITS-1:0] word_t;

  // Opcodes
  localparam op_t OP_READ   = 4'd0;
  localparam op_t OP_WRITE  = 4'd1;
  localparam op_t OP_INSERT = 4'd2;
  localparam op_t OP_ERASE  = 4'd3;
  localparam op_t OP_PUSH   = 4'd4;
  localparam op_t OP_POP    = 4'd5;
  localparam op_t OP_CLEAR  = 4'd6;
  localparam op_t OP_RESIZE = 4'd7;
  localparam op_t OP_ASSIGN = 4'd8;

  // Status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_RANGE = 2'd1;
  localparam status_t ST_FULL  = 2'd2;
  localparam status_t ST_EMPTY = 2'd3;

  // Pointer load sources
  localparam logic [1:0] PTR_NONE  = 2'd0;
  localparam logic [1:0] PTR_COUNT = 2'd1;
  localparam logic [1:0] PTR_IDX   = 2'd2;
  localparam logic [1:0] PTR_ZERO  = 2'd3;

  // Read address sources
  localparam logic [1:0] RA_IDX    = 2'd0;
  localparam logic [1:0] RA_PTR_M1 = 2'd1;
  localparam logic [1:0] RA_PTR_P1 = 2'd2;

  // Write address sources
  localparam logic [1:0] WA_IDX   = 2'd0;
  localparam logic [1:0] WA_PTR   = 2'd1;
  localparam logic [1:0] WA_COUNT = 2'd2;

  // Count updates
  localparam logic [2:0] CNT_HOLD = 3'd0;
  localparam logic [2:0] CNT_INC  = 3'd1;
  localparam logic [2:0] CNT_DEC  = 3'd2;
  localparam logic [2:0] CNT_CLR  = 3'd3;
  localparam logic [2:0] CNT_NSZ  = 3'd4;

  typedef struct packed {
    logic       load;
    logic [1:0] ptr_sel;
    logic       ptr_inc;
    logic       ptr_dec;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       wr_en;
    logic [1:0] wr_sel;
    logic       wr_rdata;
    logic [2:0] cnt_op;
    logic       out_ld;
    logic       out_rd;
  } cmd_t;

  typedef struct packed {
    op_t     op;
    status_t err;
    logic    ptr_gt_idx;
    logic    ptr_p1_lt_cnt;
    logic    ptr_lt_nsz;
  } stat_t;

endpackage
`default_nettype wire

FILE: src/oaie_if.sv
`default_nettype none
interface oaie_in_if;
  logic                               valid;
  logic                               ready;
  logic [oaie_pkg::OP_W-1:0]          opcode;
  logic [oaie_pkg::IDX_W-1:0]         index;
  logic signed [oaie_pkg::DATA_W-1:0] value;
  logic [oaie_pkg::SIZE_W-1:0]        new_size;

  modport source(output valid, output opcode, output index, output value,
                 output new_size, input ready);
  modport sink(input valid, input opcode, input index, input value,
               input new_size, output ready);
endinterface

interface oaie_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [oaie_pkg::DATA_W-1:0] read_data;
  logic [oaie_pkg::SIZE_W-1:0]        size_now;
  logic [oaie_pkg::ST_W-1:0]          status;

  modport source(output valid, output read_data, output size_now, output status,
                 input ready);
  modport sink(input valid, input read_data, input size_now, input status,
               output ready);
endinterface
`default_nettype wire

FILE: src/oaie_ctrl.sv
`default_nettype none
module oaie_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire oaie_pkg::stat_t stat,
  output oaie_pkg::cmd_t       cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_SH_RD  = 3'd2;
  localparam logic [2:0] S_SH_WR  = 3'd3;
  localparam logic [2:0] S_FILL   = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;
  logic       ok;

  assign out_free = !out_valid || out_ready;
  assign ok       = (stat.err == oaie_pkg::ST_OK);
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = S_FINISH;
        if (ok) begin
          unique case (stat.op)
            oaie_pkg::OP_READ: begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = oaie_pkg::RA_IDX;
            end
            oaie_pkg::OP_INSERT: begin
              cmd.ptr_sel = oaie_pkg::PTR_COUNT;
              state_next  = S_SH_RD;
            end
            oaie_pkg::OP_ERASE: begin
              cmd.ptr_sel = oaie_pkg::PTR_IDX;
              state_next  = S_SH_RD;
            end
            oaie_pkg::OP_RESIZE: begin
              cmd.ptr_sel = oaie_pkg::PTR_COUNT;
              state_next  = S_FILL;
            end
            oaie_pkg::OP_ASSIGN: begin
              cmd.ptr_sel = oaie_pkg::PTR_ZERO;
              state_next  = S_FILL;
            end
            default: state_next = S_FINISH;
          endcase
        end
      end
      S_SH_RD: begin
        // Fetch the neighbor that moves into the slot under the pointer
        if (stat.op == oaie_pkg::OP_INSERT) begin
          if (stat.ptr_gt_idx) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = oaie_pkg::RA_PTR_M1;
            state_next = S_SH_WR;
          end else begin
            state_next = S_FINISH;
          end
        end else begin
          if (stat.ptr_p1_lt_cnt) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = oaie_pkg::RA_PTR_P1;
            state_next = S_SH_WR;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_SH_WR: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_sel   = oaie_pkg::WA_PTR;
        cmd.wr_rdata = 1'b1;
        if (stat.op == oaie_pkg::OP_INSERT) begin
          cmd.ptr_dec = 1'b1;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
        state_next = S_SH_RD;
      end
      S_FILL: begin
        if (stat.ptr_lt_nsz) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = oaie_pkg::WA_PTR;
          cmd.ptr_inc = 1'b1;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        // Hold until the output register is free, then commit
        if (out_free) begin
          cmd.out_ld = 1'b1;
          state_next = S_IDLE;
          if (ok) begin
            unique case (stat.op)
              oaie_pkg::OP_READ:  cmd.out_rd = 1'b1;
              oaie_pkg::OP_WRITE: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = oaie_pkg::WA_IDX;
              end
              oaie_pkg::OP_INSERT: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = oaie_pkg::WA_IDX;
                cmd.cnt_op = oaie_pkg::CNT_INC;
              end
              oaie_pkg::OP_ERASE: cmd.cnt_op = oaie_pkg::CNT_DEC;
              oaie_pkg::OP_PUSH: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = oaie_pkg::WA_COUNT;
                cmd.cnt_op = oaie_pkg::CNT_INC;
              end
              oaie_pkg::OP_POP:    cmd.cnt_op = oaie_pkg::CNT_DEC;
              oaie_pkg::OP_CLEAR:  cmd.cnt_op = oaie_pkg::CNT_CLR;
              oaie_pkg::OP_RESIZE: cmd.cnt_op = oaie_pkg::CNT_NSZ;
              oaie_pkg::OP_ASSIGN: cmd.cnt_op = oaie_pkg::CNT_NSZ;
              default:             cmd.cnt_op = oaie_pkg::CNT_HOLD;
            endcase
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_ld) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/oaie_dp.sv
`default_nettype none
module oaie_dp (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire oaie_pkg::cmd_t                     cmd,
  output oaie_pkg::stat_t                         stat,
  input  wire logic [oaie_pkg::OP_W-1:0]          opcode,
  input  wire logic [oaie_pkg::IDX_W-1:0]         index,
  input  wire logic signed [oaie_pkg::DATA_W-1:0] value,
  input  wire logic [oaie_pkg::SIZE_W-1:0]        new_size,
  output logic signed [oaie_pkg::DATA_W-1:0]      read_data,
  output logic [oaie_pkg::SIZE_W-1:0]             size_now,
  output logic [oaie_pkg::ST_W-1:0]               status
);

  localparam int CMP_W = oaie_pkg::CMP_W;
  localparam int ADDR_W = oaie_pkg::ADDR_W;

  // Latched item
  oaie_pkg::op_t               op;
  logic [oaie_pkg::IDX_W-1:0]  idx;
  oaie_pkg::word_t             word;
  logic [oaie_pkg::SIZE_W-1:0] nsz;

  oaie_pkg::cnt_t count;
  oaie_pkg::cnt_t count_next;
  oaie_pkg::cnt_t ptr;

  oaie_pkg::word_t mem [oaie_pkg::DEPTH];
  oaie_pkg::word_t rdata;
  oaie_pkg::addr_t rd_addr;
  oaie_pkg::addr_t wr_addr;
  oaie_pkg::word_t wr_data;

  logic [CMP_W-1:0] idx_c;
  logic [CMP_W-1:0] cnt_c;
  logic [CMP_W-1:0] nsz_c;
  logic [CMP_W-1:0] ptr_c;
  logic [CMP_W-1:0] depth_c;
  oaie_pkg::status_t err;

  assign idx_c   = CMP_W'(idx);
  assign cnt_c   = CMP_W'(count);
  assign nsz_c   = CMP_W'(nsz);
  assign ptr_c   = CMP_W'(ptr);
  assign depth_c = CMP_W'(oaie_pkg::DEPTH);

  always_comb begin
    err = oaie_pkg::ST_OK;
    unique case (op)
      oaie_pkg::OP_READ, oaie_pkg::OP_WRITE, oaie_pkg::OP_ERASE: begin
        if (idx_c >= cnt_c) err = oaie_pkg::ST_RANGE;
      end
      oaie_pkg::OP_INSERT: begin
        if (idx_c > cnt_c) begin
          err = oaie_pkg::ST_RANGE;
        end else if (cnt_c == depth_c) begin
          err = oaie_pkg::ST_FULL;
        end
      end
      oaie_pkg::OP_PUSH: begin
        if (cnt_c == depth_c) err = oaie_pkg::ST_FULL;
      end
      oaie_pkg::OP_POP: begin
        if (count == '0) err = oaie_pkg::ST_EMPTY;
      end
      oaie_pkg::OP_RESIZE, oaie_pkg::OP_ASSIGN: begin
        if (nsz_c > depth_c) err = oaie_pkg::ST_FULL;
      end
      default: err = oaie_pkg::ST_OK;
    endcase
  end

  assign stat.op            = op;
  assign stat.err           = err;
  assign stat.ptr_gt_idx    = (ptr_c > idx_c);
  assign stat.ptr_p1_lt_cnt = ((ptr_c + CMP_W'(1)) < cnt_c);
  assign stat.ptr_lt_nsz    = (ptr_c < nsz_c);

  always_comb begin
    unique case (cmd.cnt_op)
      oaie_pkg::CNT_INC: count_next = count + oaie_pkg::cnt_t'(1);
      oaie_pkg::CNT_DEC: count_next = count - oaie_pkg::cnt_t'(1);
      oaie_pkg::CNT_CLR: count_next = '0;
      oaie_pkg::CNT_NSZ: count_next = oaie_pkg::cnt_t'(nsz);
      default:           count_next = count;
    endcase
  end

  // Address and data selection for the storage array
  always_comb begin
    unique case (cmd.rd_sel)
      oaie_pkg::RA_PTR_M1: rd_addr = ADDR_W'(ptr - oaie_pkg::cnt_t'(1));
      oaie_pkg::RA_PTR_P1: rd_addr = ADDR_W'(ptr + oaie_pkg::cnt_t'(1));
      default:             rd_addr = idx[ADDR_W-1:0];
    endcase
    unique case (cmd.wr_sel)
      oaie_pkg::WA_PTR:   wr_addr = ptr[ADDR_W-1:0];
      oaie_pkg::WA_COUNT: wr_addr = count[ADDR_W-1:0];
      default:            wr_addr = idx[ADDR_W-1:0];
    endcase
    wr_data = cmd.wr_rdata ? rdata : word;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= opcode;
      idx  <= index;
      word <= oaie_pkg::WORD_BITS'(value);
      nsz  <= new_size;
    end
    unique case (cmd.ptr_sel)
      oaie_pkg::PTR_COUNT: ptr <= count;
      oaie_pkg::PTR_IDX:   ptr <= oaie_pkg::cnt_t'(idx);
      oaie_pkg::PTR_ZERO:  ptr <= '0;
      default: begin
        if (cmd.ptr_inc) begin
          ptr <= ptr + oaie_pkg::cnt_t'(1);
        end else if (cmd.ptr_dec) begin
          ptr <= ptr - oaie_pkg::cnt_t'(1);
        end
      end
    endcase
    if (cmd.out_ld) begin
      read_data <= cmd.out_rd ? oaie_pkg::DATA_W'(rdata) : '0;
      size_now  <= oaie_pkg::SIZE_W'(count_next);
      status    <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule
`default_nettype wire

FILE: src/ordered_array_insert_erase_core.sv
// Bounded vector of signed words with positional insert and erase.
//
// Channels: in_ch carries one command per beat (opcode, index, value,
// new_size); out_ch returns one result beat per command (read_data,
// size_now, status). Both use valid/ready; a beat moves when both are high.
//
// Sequencing: one command is worked on at a time. in_ch.ready is high only
// while the controller is idle. Read, write, push, pop, clear and failed
// commands go straight from the check to the commit, where the result is
// registered; insert and erase first shift words one at a time (each word
// is read from storage in one state and written back in the next), and
// resize and assign first fill words one at a time, none for a shrinking
// resize. The next command can be accepted in the cycle after the commit.
//
// Reset clears the count to zero; the stored words are left as they are and
// never read before being written. A result waits in the output register
// while out_ch.ready is low; the next command may already be accepted and
// worked on, and it holds before committing until the register is free.
`default_nettype none
module ordered_array_insert_erase_core (
  input  wire logic   clk,
  input  wire logic   rst,
  oaie_in_if.sink     in_ch,
  oaie_out_if.source  out_ch
);

  oaie_pkg::cmd_t  cmd;
  oaie_pkg::stat_t stat;

  // Sequence each command: accept, check, shift or fill, commit
  oaie_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold the storage array, the count and the result register
  oaie_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .opcode    (in_ch.opcode),
    .index     (in_ch.index),
    .value     (in_ch.value),
    .new_size  (in_ch.new_size),
    .read_data (out_ch.read_data),
    .size_now  (out_ch.size_now),
    .status    (out_ch.status)
  );

endmodule
`default_nettype wire
